>>> rtl/ecc_pkg.sv
// Package for the elevator cabin controller: motion and item-kind codes,
// register indexes, field widths and reset values. No dependencies.
`default_nettype none

package ecc_pkg;

    localparam int FLOOR_W = 6;

    typedef enum logic [1:0] {
        MOT_STOP = 2'd0,
        MOT_UP   = 2'd1,
        MOT_DOWN = 2'd2
    } t_motion;

    typedef enum logic [1:0] {
        KIND_CABIN = 2'd0,
        KIND_HALL  = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    localparam logic REG_NUM_FLOORS  = 1'b0;
    localparam logic REG_START_FLOOR = 1'b1;

    localparam logic [FLOOR_W-1:0] NUM_FLOORS_RST  = 6'd32;
    localparam logic [FLOOR_W-1:0] START_FLOOR_RST = 6'd1;

endpackage

`default_nettype wire

>>> rtl/elevator_cabin_controller.sv
// Single-cabin elevator scheduler: request masks, cabin floor and motion state.
// An accepted input beat passes the input register, then the result register, to
// its result beat. Throughput: one beat per cycle unless i_m_tready stalls output.
// The nearest-request priority encoders sit between the two registers.
// Reset (synchronous, active low): requests cleared, motion and direction
// stopped, num_floors = 32, start_floor = 1, cabin at floor 1.
// Any register write re-initializes the cabin the same way with the new values.
// Depends on ecc_pkg.
`default_nettype none

module elevator_cabin_controller #(
    parameter int MAX_FLOORS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input beat
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [7:0]                  i_s_tdata,   // [5:0] floor
    input  wire logic [1:0]                  i_s_tuser,   // [1:0] kind
    // result beat
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // [5:0] current_floor, [7:6] cabin_state, [9:8] travel_direction,
    // [10] request_ignored
    output logic [15:0]                      o_m_tdata,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import ecc_pkg::*;

    localparam int M = MAX_FLOORS;
    localparam logic [FLOOR_W:0] MaxFloorsW = (FLOOR_W+1)'(MAX_FLOORS);

    function automatic logic [FLOOR_W-1:0] eff_floors(input logic [FLOOR_W-1:0] nf);
        logic [FLOOR_W-1:0] r;
        if (nf == '0) begin
            r = FLOOR_W'(1);
        end else if ({1'b0, nf} > MaxFloorsW) begin
            r = MaxFloorsW[FLOOR_W-1:0];
        end else begin
            r = nf;
        end
        return r;
    endfunction

    function automatic logic [FLOOR_W-1:0] clamp_start(input logic [FLOOR_W-1:0] sf,
                                                       input logic [FLOOR_W-1:0] n);
        logic [FLOOR_W-1:0] r;
        if (sf == '0) begin
            r = FLOOR_W'(1);
        end else if (sf > n) begin
            r = n;
        end else begin
            r = sf;
        end
        return r;
    endfunction

    function automatic logic [FLOOR_W-1:0] lowest_floor(input logic [M-1:0] m);
        logic [FLOOR_W-1:0] r;
        r = '0;
        for (int i = M - 1; i >= 0; i--) begin
            if (m[i]) r = FLOOR_W'(i + 1);
        end
        return r;
    endfunction

    function automatic logic [FLOOR_W-1:0] highest_floor(input logic [M-1:0] m);
        logic [FLOOR_W-1:0] r;
        r = '0;
        for (int i = 0; i < M; i++) begin
            if (m[i]) r = FLOOR_W'(i + 1);
        end
        return r;
    endfunction

    // nearest requested floor, lower floor wins a tie; zero when none
    function automatic logic [FLOOR_W-1:0] nearest_any(input logic [M-1:0] m,
                                                       input logic [M-1:0] here,
                                                       input logic [M-1:0] above,
                                                       input logic [M-1:0] below,
                                                       input logic [FLOOR_W-1:0] cf);
        logic [FLOOR_W-1:0] b;
        logic [FLOOR_W-1:0] a;
        logic [FLOOR_W-1:0] r;
        b = highest_floor(m & below);
        a = lowest_floor(m & above);
        if (|(m & here)) begin
            r = cf;
        end else if (b != '0 && a != '0) begin
            r = ((cf - b) <= (a - cf)) ? b : a;
        end else if (b != '0) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

    // configuration registers
    logic [FLOOR_W-1:0] r_num_floors, n_num_floors;
    logic [FLOOR_W-1:0] r_start_floor, n_start_floor;

    // cabin state
    logic [M-1:0]       r_cabin_bits, n_cabin_bits;
    logic [M-1:0]       r_up_bits, n_up_bits;
    logic [M-1:0]       r_down_bits, n_down_bits;
    logic [FLOOR_W-1:0] r_floor, n_floor;
    t_motion            r_motion, n_motion;
    t_motion            r_dir, n_dir;

    // input stage
    logic               r_in_valid;
    logic [1:0]         r_in_kind;
    logic [FLOOR_W-1:0] r_in_floor;

    // result stage
    logic               r_out_valid;
    logic [FLOOR_W-1:0] r_out_floor;
    t_motion            r_out_motion;
    t_motion            r_out_dir;
    logic               r_out_ignored;
    logic               n_ignored;

    logic               cfg_wr;
    logic               adv;
    logic               in_acc;
    logic [FLOOR_W-1:0] eff_n;
    logic [FLOOR_W-1:0] moved_floor;
    logic [FLOOR_W-1:0] eval_floor;
    logic [M-1:0]       here_m;
    logic [M-1:0]       above_m;
    logic [M-1:0]       below_m;
    logic [M-1:0]       sel_m;
    logic [M-1:0]       valid_m;
    logic [M-1:0]       all_m;
    logic [FLOOR_W-1:0] tgt_cabin;
    logic [FLOOR_W-1:0] tgt_hall;
    logic [FLOOR_W-1:0] tgt;
    logic               floor_bad;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_START_FLOOR) ? {26'd0, r_start_floor}
                                                  : {26'd0, r_num_floors};

    // handshake
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_ignored, r_out_dir, r_out_motion, r_out_floor};

    assign eff_n = eff_floors(r_num_floors);

    always_comb begin
        unique case (r_motion)
            MOT_UP:   moved_floor = (r_floor < eff_n) ? r_floor + FLOOR_W'(1) : r_floor;
            MOT_DOWN: moved_floor = (r_floor > FLOOR_W'(1)) ? r_floor - FLOOR_W'(1) : r_floor;
            default:  moved_floor = r_floor;
        endcase
        eval_floor = moved_floor;
    end

    always_comb begin
        for (int i = 0; i < M; i++) begin
            here_m[i]  = ((FLOOR_W+1)'(i + 1) == {1'b0, eval_floor});
            above_m[i] = ((FLOOR_W+1)'(i + 1) >  {1'b0, eval_floor});
            below_m[i] = ((FLOOR_W+1)'(i + 1) <  {1'b0, eval_floor});
            sel_m[i]   = ((FLOOR_W+1)'(i + 1) == {1'b0, r_in_floor});
            valid_m[i] = ((FLOOR_W+1)'(i + 1) <= {1'b0, eff_n});
        end
    end

    assign all_m     = r_cabin_bits | r_up_bits | r_down_bits;
    assign tgt_cabin = nearest_any(r_cabin_bits, here_m, above_m, below_m, eval_floor);
    assign tgt_hall  = nearest_any(r_up_bits | r_down_bits, here_m, above_m, below_m,
                                   eval_floor);
    assign tgt       = (tgt_cabin != '0) ? tgt_cabin : tgt_hall;
    assign floor_bad = (r_in_floor == '0) || (r_in_floor > eff_n);

    always_comb begin
        n_num_floors  = r_num_floors;
        n_start_floor = r_start_floor;
        n_cabin_bits  = r_cabin_bits;
        n_up_bits     = r_up_bits;
        n_down_bits   = r_down_bits;
        n_floor       = r_floor;
        n_motion      = r_motion;
        n_dir         = r_dir;
        n_ignored     = 1'b0;

        if (cfg_wr) begin
            if (paddr[2] == REG_START_FLOOR) begin
                n_start_floor = pwdata[FLOOR_W-1:0];
            end else begin
                n_num_floors = pwdata[FLOOR_W-1:0];
            end
            n_cabin_bits = '0;
            n_up_bits    = '0;
            n_down_bits  = '0;
            n_motion     = MOT_STOP;
            n_dir        = MOT_STOP;
            n_floor      = clamp_start(n_start_floor, eff_floors(n_num_floors));
        end else if (adv) begin
            unique case (r_in_kind)
                KIND_CABIN, KIND_HALL: begin
                    if (floor_bad) begin
                        n_ignored = 1'b1;
                    end else if (r_in_kind == KIND_CABIN) begin
                        n_cabin_bits = r_cabin_bits | sel_m;
                    end else if (r_in_floor == FLOOR_W'(1)) begin
                        n_up_bits = r_up_bits | sel_m;
                    end else begin
                        n_down_bits = r_down_bits | sel_m;
                    end
                end
                KIND_TICK: begin
                    priority if (r_motion == MOT_STOP && r_dir == MOT_STOP) begin
                        // start from rest
                        if (tgt != '0) begin
                            if (tgt < r_floor) begin
                                n_dir    = MOT_DOWN;
                                n_motion = MOT_DOWN;
                            end else if (tgt > r_floor) begin
                                n_dir    = MOT_UP;
                                n_motion = MOT_UP;
                            end else begin
                                n_cabin_bits = r_cabin_bits & ~here_m;
                                n_up_bits    = r_up_bits & ~here_m;
                                n_down_bits  = r_down_bits & ~here_m;
                            end
                        end
                    end else if (r_motion == MOT_UP || r_motion == MOT_DOWN) begin
                        // one floor on, then stop checks at the new floor
                        n_floor = moved_floor;
                        priority if (|(r_cabin_bits & here_m)) begin
                            n_cabin_bits = r_cabin_bits & ~here_m;
                            n_motion     = MOT_STOP;
                        end else if (|(r_down_bits & here_m) && r_motion == MOT_DOWN) begin
                            n_down_bits = r_down_bits & ~here_m;
                            n_motion    = MOT_STOP;
                        end else if (|(r_up_bits & here_m) && r_motion == MOT_UP) begin
                            n_up_bits = r_up_bits & ~here_m;
                            n_motion  = MOT_STOP;
                        end else if (|(r_down_bits & here_m) && r_motion == MOT_UP
                                     && !(|(all_m & above_m))) begin
                            n_down_bits = r_down_bits & ~here_m;
                            n_motion    = MOT_STOP;
                        end else if (|(r_up_bits & here_m) && r_motion == MOT_DOWN
                                     && !(|(all_m & below_m))) begin
                            n_up_bits = r_up_bits & ~here_m;
                            n_motion  = MOT_STOP;
                        end else begin
                            n_motion = r_motion;
                        end
                    end else begin
                        // stopped with a direction kept
                        priority if (r_dir == MOT_UP
                                     && |((r_cabin_bits | r_up_bits) & above_m)) begin
                            n_motion = MOT_UP;
                        end else if (r_dir == MOT_DOWN
                                     && |((r_cabin_bits | r_down_bits) & below_m)) begin
                            n_motion = MOT_DOWN;
                        end else if (tgt != '0) begin
                            n_dir    = (tgt > r_floor) ? MOT_UP : MOT_DOWN;
                            n_motion = (tgt > r_floor) ? MOT_UP : MOT_DOWN;
                        end else begin
                            n_dir = MOT_STOP;
                        end
                    end
                end
                default: begin
                    n_ignored = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_floors  <= NUM_FLOORS_RST;
            r_start_floor <= START_FLOOR_RST;
            r_cabin_bits  <= '0;
            r_up_bits     <= '0;
            r_down_bits   <= '0;
            r_floor       <= clamp_start(START_FLOOR_RST, eff_floors(NUM_FLOORS_RST));
            r_motion      <= MOT_STOP;
            r_dir         <= MOT_STOP;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_num_floors  <= n_num_floors;
            r_start_floor <= n_start_floor;
            r_cabin_bits  <= n_cabin_bits;
            r_up_bits     <= n_up_bits;
            r_down_bits   <= n_down_bits;
            r_floor       <= n_floor;
            r_motion      <= n_motion;
            r_dir         <= n_dir;
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_kind  <= i_s_tuser;
            r_in_floor <= i_s_tdata[FLOOR_W-1:0];
        end
        if (adv) begin
            r_out_floor   <= n_floor;
            r_out_motion  <= n_motion;
            r_out_dir     <= n_dir;
            r_out_ignored <= n_ignored;
        end
    end

`ifndef SYNTHESIS
    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_floor >= FLOOR_W'(1)) && (r_floor <= eff_n))
        else $error("cabin floor outside served floors");

    a_motion_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_motion != MOT_STOP) |-> (r_motion == r_dir))
        else $error("cabin moving against kept direction");

    a_no_stray_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cabin_bits | r_up_bits | r_down_bits) & ~valid_m) == '0)
        else $error("request held for a floor not served");

    a_ignored_only_requests: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_ignored) |=> (r_out_valid && r_out_ignored && $stable(r_floor)))
        else $error("ignored request changed cabin floor");
`endif

endmodule

`default_nettype wire
